// ===== rtl/psg_tone_noise_synth_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sound generator block.
// Each macro checks an implication on the rising edge of clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_SYNTH_MACROS_SVH
`define PSG_TONE_NOISE_SYNTH_MACROS_SVH

// Same-cycle implication.
`define PSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the tone and noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CLOCK_IN      = 3'd0,
    CFG_SAMPLE_RATE   = 3'd1,
    CFG_LFSR_PRESET   = 3'd2,
    CFG_WHITE_TAPS    = 3'd3,
    CFG_PERIODIC_TAPS = 3'd4
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [21:0] CLOCK_IN_RST      = 22'd3579545;
  localparam logic [17:0] SAMPLE_RATE_RST   = 18'd44100;
  localparam logic [31:0] LFSR_PRESET_RST   = 32'd16384;
  localparam logic [31:0] WHITE_TAPS_RST    = 32'd73728;
  localparam logic [31:0] PERIODIC_TAPS_RST = 32'd65536;

  // Noise increment after reset, from the reset clock and sample rate.
  localparam logic [31:0] NOISE_INC_RST =
    32'(((64'd3579545 / 64'd512) << 16) / 64'd44100);

  // Serial divider widths.
  localparam int DIV_DW = 38;
  localparam int DIV_SW = 18;

  // Channel of the noise generator.
  localparam logic [1:0] NOISE_CH = 2'd3;

  // Operation classes produced by the front end.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_TICK    = 3'd1,
    OP_VOL     = 3'd2,
    OP_TONE_LO = 3'd3,
    OP_NOISE   = 3'd4,
    OP_DIV_HI  = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               chip;
    logic               chip_ok;
    logic [1:0]         ch;
    logic [5:0]         arg;
    logic signed [15:0] mix;
  } psg_op_t;

  typedef struct packed {
    logic [21:0] clock_in;
    logic [17:0] sample_rate;
    logic [31:0] lfsr_preset;
    logic [31:0] white_taps;
    logic [31:0] periodic_taps;
  } psg_cfg_t;

  // Full state of one generator, read and written as one row.
  typedef struct packed {
    logic [3:0][9:0]  divider;
    logic [3:0][12:0] volume;
    logic [3:0]       muted;
    logic [3:0]       polarity;
    logic [3:0][31:0] phase;
    logic [3:0][31:0] increment;
    logic [31:0]      lfsr;
    logic [2:0]       mode;
    logic             white;
  } chip_row_t;

  typedef struct packed {
    logic idle;
    logic div_busy;
    logic summing;
  } psg_bk_st_t;

  // Attenuation table entry: 2 dB steps down from full scale.
  function automatic logic [12:0] vol_entry(input int unsigned full, input int idx);
    logic [63:0] acc;
    logic [12:0] res;
    acc = 64'(full) << 22;
    for (int i = 1; i <= 14; i++) begin
      if (i <= idx) begin
        acc = (acc * 64'd250000000) / 64'd314731353;
      end
    end
    if (idx == 0) begin
      res = 13'(full);
    end else if (idx >= 15) begin
      res = '0;
    end else begin
      res = acc[34:22];
    end
    return res;
  endfunction

endpackage

// ===== rtl/psg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_front
// Accepts input transactions, classifies command bytes and queues them.
// ----------------------------------------------------------------------------
module psg_front import psg_pkg::*; #(
  parameter int NUM_CHIPS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_chip,
  input  logic [7:0]         in_data,
  input  logic signed [15:0] in_mix_in,
  output logic               q_valid,
  output psg_op_t            q_op,
  input  logic               q_pop,
  output logic [1:0]         fq_count
);

  logic [1:0] cur_ch_r [NUM_CHIPS];
  psg_op_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  psg_op_t    op_c;
  logic       push;
  logic       chip_ok;

  assign chip_ok  = (32'(in_chip) < NUM_CHIPS);
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_op     = mem_r[rd_ptr_r];
  assign fq_count = count_r;

  // Classify the incoming transaction.
  always_comb begin
    op_c         = '0;
    op_c.chip    = in_chip;
    op_c.chip_ok = chip_ok;
    op_c.mix     = in_mix_in;
    op_c.kind    = OP_NONE;
    if (in_cmd) begin
      op_c.kind = OP_TICK;
    end else if (chip_ok) begin
      if (in_data[7]) begin
        op_c.ch = in_data[6:5];
        if (in_data[4]) begin
          op_c.kind = OP_VOL;
          op_c.arg  = {2'b00, in_data[3:0]};
        end else if (in_data[6:5] != NOISE_CH) begin
          op_c.kind = OP_TONE_LO;
          op_c.arg  = {2'b00, in_data[3:0]};
        end else begin
          op_c.kind = OP_NOISE;
          op_c.arg  = {3'b000, in_data[2:0]};
        end
      end else begin
        op_c.kind = OP_DIV_HI;
        op_c.ch   = cur_ch_r[in_chip];
        op_c.arg  = in_data[5:0];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Queue pointers and latched channel per generator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
      for (int c = 0; c < NUM_CHIPS; c++) begin
        cur_ch_r[c] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
        if (!in_cmd && chip_ok && in_data[7]) begin
          cur_ch_r[in_chip] <= in_data[6:5];
        end
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_c;
    end
  end

endmodule

// ===== rtl/psg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div import psg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_SW-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_DW-1:0] quot
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic [DIV_DW-1:0] quot_r;
  logic [DIV_SW-1:0] rem_r;
  logic [DIV_SW-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_SW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quot_r[DIV_DW-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign busy  = busy_r;
  assign done  = done_r;
  assign quot  = quot_r;

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIV_DW-2:0], fits};
      rem_r  <= fits ? DIV_SW'(trial - {1'b0, dvs_r}) : trial[DIV_SW-1:0];
    end
  end

endmodule

// ===== rtl/psg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_back
// Executes queued operations: register updates, increment computation
// through the serial divider, sample ticks and the output register.
// ----------------------------------------------------------------------------
module psg_back import psg_pkg::*; #(
  parameter int NUM_CHIPS         = 2,
  parameter int VOLUME_FULL_SCALE = 7680
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psg_cfg_t           cfg,
  input  logic               q_valid,
  input  psg_op_t            q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_chip_out,
  output psg_bk_st_t         bk_st
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_SUM  = 4'b1000
  } bk_state_t;

  bk_state_t          state_r, state_nxt;
  psg_op_t            op_r, op_nxt;
  chip_row_t          rows_r [NUM_CHIPS];
  chip_row_t          row_cur, row_nxt, row_tick;
  logic               row_we;
  logic [1:0]         job_ch_r, job_ch_nxt;
  logic               job_stage_r, job_stage_nxt;
  logic               job_dbl_r, job_dbl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_sample_r, out_sample_nxt;
  logic               out_chip_r, out_chip_nxt;
  logic [12:0]        vol_tab [16];

  logic               div_start;
  logic [DIV_DW-1:0]  div_dividend;
  logic [DIV_SW-1:0]  div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [DIV_DW-1:0]  div_quot;

  logic               tone_go;
  logic [9:0]         tone_d;
  logic [1:0]         tone_tgt;
  logic               noise_go;
  logic [1:0]         noise_r;
  logic [12:0]        f_noise;
  logic               sr_zero;
  logic [DIV_DW:0]    q_ext;
  logic [31:0]        inc_sat;
  logic signed [15:0] sum_s;
  logic signed [17:0] mix_s;
  logic signed [15:0] sat_s;
  logic               out_free;

  // Attenuation table, fixed at elaboration.
  for (genvar i = 0; i < 16; i++) begin : g_vol
    assign vol_tab[i] = vol_entry(VOLUME_FULL_SCALE, i);
  end

  psg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign row_cur  = rows_r[op_r.chip];
  assign sr_zero  = (cfg.sample_rate == '0);
  assign out_free = !out_valid_r || !out_stall;
  assign f_noise  = 13'(cfg.clock_in[21:9] >> noise_r);
  assign q_ext    = job_dbl_r ? {div_quot, 1'b0} : {1'b0, div_quot};
  assign inc_sat  = (|q_ext[DIV_DW:32]) ? 32'hFFFF_FFFF : q_ext[31:0];

  // One sample step of every audible channel of the addressed generator.
  always_comb begin
    logic [31:0] ps;
    logic [31:0] lf;
    ps       = '0;
    lf       = '0;
    row_tick = row_cur;
    for (int j = 0; j < 4; j++) begin
      ps = row_cur.phase[j] + row_cur.increment[j];
      if (row_cur.volume[j] != '0 && !row_cur.muted[j]) begin
        row_tick.phase[j] = ps;
        if (ps[16]) begin
          row_tick.phase[j] = {16'h0000, ps[15:0]};
          if (j != 3) begin
            row_tick.polarity[j] = !row_cur.polarity[j];
          end else begin
            lf = row_cur.lfsr;
            if (lf[0]) begin
              lf = lf ^ (row_cur.white ? cfg.white_taps : cfg.periodic_taps);
            end
            lf = lf >> 1;
            row_tick.lfsr        = lf;
            row_tick.polarity[3] = lf[0];
          end
        end
      end
    end
  end

  // Channel sum and saturated mix.
  always_comb begin
    sum_s = '0;
    if (op_r.chip_ok) begin
      for (int j = 0; j < 4; j++) begin
        if (row_cur.volume[j] != '0 && !row_cur.muted[j]) begin
          if (row_cur.polarity[j]) begin
            sum_s = sum_s - $signed({3'b000, row_cur.volume[j]});
          end else begin
            sum_s = sum_s + $signed({3'b000, row_cur.volume[j]});
          end
        end
      end
    end
    mix_s = {{2{op_r.mix[15]}}, op_r.mix} + {{2{sum_s[15]}}, sum_s};
    if (mix_s > 18'sd32767) begin
      sat_s = 16'sh7FFF;
    end else if (mix_s < -18'sd32768) begin
      sat_s = 16'sh8000;
    end else begin
      sat_s = mix_s[15:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    row_nxt        = row_cur;
    row_we         = 1'b0;
    q_pop          = 1'b0;
    job_ch_nxt     = job_ch_r;
    job_stage_nxt  = job_stage_r;
    job_dbl_nxt    = job_dbl_r;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    tone_go        = 1'b0;
    tone_d         = '0;
    tone_tgt       = '0;
    noise_go       = 1'b0;
    noise_r        = '0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_chip_nxt   = out_chip_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_op;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (op_r.kind)
          OP_TICK: begin
            if (op_r.chip_ok) begin
              row_nxt = row_tick;
              row_we  = 1'b1;
            end
            state_nxt = S_SUM;
          end
          OP_VOL: begin
            row_nxt.volume[op_r.ch] = vol_tab[op_r.arg[3:0]];
            row_we = 1'b1;
          end
          OP_TONE_LO: begin
            row_nxt.divider[op_r.ch][3:0] = op_r.arg[3:0];
            row_we = 1'b1;
          end
          OP_NOISE: begin
            row_nxt.mode        = op_r.arg[2:0];
            row_nxt.white       = op_r.arg[2];
            row_nxt.lfsr        = cfg.lfsr_preset;
            row_nxt.polarity[3] = cfg.lfsr_preset[0];
            row_we              = 1'b1;
            if (op_r.arg[1:0] == 2'd3) begin
              tone_go  = 1'b1;
              tone_d   = row_cur.divider[2];
              tone_tgt = NOISE_CH;
            end else begin
              noise_go = 1'b1;
              noise_r  = op_r.arg[1:0];
            end
          end
          OP_DIV_HI: begin
            row_nxt.divider[op_r.ch][9:4] = op_r.arg;
            row_we = 1'b1;
            if (op_r.ch != NOISE_CH) begin
              tone_go  = 1'b1;
              tone_d   = {op_r.arg, row_cur.divider[op_r.ch][3:0]};
              tone_tgt = op_r.ch;
            end else if (row_cur.mode[1:0] == 2'd3) begin
              tone_go  = 1'b1;
              tone_d   = row_cur.divider[2];
              tone_tgt = NOISE_CH;
            end
          end
          default: begin
          end
        endcase

        // Tone increment: mute or start clock / (32 * divider).
        if (tone_go) begin
          if (tone_d <= 10'd2) begin
            row_nxt.muted[tone_tgt] = 1'b1;
          end else begin
            row_nxt.muted[tone_tgt] = 1'b0;
            div_start     = 1'b1;
            div_dividend  = {21'd0, cfg.clock_in[21:5]};
            div_divisor   = {8'd0, tone_d};
            job_ch_nxt    = tone_tgt;
            job_stage_nxt = 1'b0;
            job_dbl_nxt   = 1'b1;
            state_nxt     = S_DIV;
          end
        end

        // Noise increment: shifted clock scaled by the sample rate.
        if (noise_go) begin
          row_nxt.muted[NOISE_CH] = 1'b0;
          if (sr_zero) begin
            row_nxt.increment[NOISE_CH] = '0;
          end else begin
            div_start     = 1'b1;
            div_dividend  = {9'd0, f_noise, 16'h0000};
            div_divisor   = cfg.sample_rate;
            job_ch_nxt    = NOISE_CH;
            job_stage_nxt = 1'b1;
            job_dbl_nxt   = 1'b0;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!job_stage_r) begin
            if (sr_zero) begin
              row_nxt.increment[job_ch_r] = '0;
              row_we    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              div_start     = 1'b1;
              div_dividend  = {5'd0, div_quot[16:0], 16'h0000};
              div_divisor   = cfg.sample_rate;
              job_stage_nxt = 1'b1;
            end
          end else begin
            row_nxt.increment[job_ch_r] = inc_sat;
            row_we    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sat_s;
          out_chip_nxt   = op_r.chip;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Generator state rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHIPS; c++) begin
        rows_r[c]              <= '0;
        rows_r[c].lfsr         <= LFSR_PRESET_RST;
        rows_r[c].polarity[3]  <= LFSR_PRESET_RST[0];
        rows_r[c].increment[3] <= NOISE_INC_RST;
      end
    end else if (row_we) begin
      rows_r[op_r.chip] <= row_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    job_ch_r     <= job_ch_nxt;
    job_stage_r  <= job_stage_nxt;
    job_dbl_r    <= job_dbl_nxt;
    out_sample_r <= out_sample_nxt;
    out_chip_r   <= out_chip_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_chip_out = out_chip_r;

  assign bk_st.idle     = (state_r == S_IDLE);
  assign bk_st.div_busy = div_busy;
  assign bk_st.summing  = (state_r == S_SUM);

endmodule

// ===== rtl/psg_tone_noise_synth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_tone_noise_synth
// Generators of three square-wave tones and one noise channel each.
// Usage: the input channel (in_valid/in_stall) carries a transaction with
// in_cmd 0 for a command byte (in_data) or 1 for a sample tick that adds
// the generator output to in_mix_in. Each tick gives one result on the
// output channel (out_valid/out_stall); a command byte gives none.
// Transactions enter a two-entry queue and are executed in order.
// A tick passes through the queue, the execute state and the summing
// state into the output register. A volume or low-divider byte is done
// in the execute state; a byte that sets a tone increment runs up to
// two 38-step serial divisions, a fixed-rate noise byte at most one.
// Configuration (cfg_valid/cfg_ready) is always ready; the user must
// write it only while the block is idle; the block does not enforce it.
// Reset clears the queue and loads all generators and cfg registers with
// their reset values. A stalled result holds in the output register; the
// next tick waits for it, while the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`include "psg_tone_noise_synth_macros.svh"

module psg_tone_noise_synth import psg_pkg::*; #(
  parameter int NUM_CHIPS         = 2,
  parameter int VOLUME_FULL_SCALE = 7680
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_chip,
  input  logic [7:0]         in_data,
  input  logic signed [15:0] in_mix_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_chip_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  psg_cfg_t   cfg_r;
  logic       q_valid;
  psg_op_t    q_op;
  logic       q_pop;
  logic [1:0] fq_count;
  psg_bk_st_t bk_st;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_in      <= CLOCK_IN_RST;
      cfg_r.sample_rate   <= SAMPLE_RATE_RST;
      cfg_r.lfsr_preset   <= LFSR_PRESET_RST;
      cfg_r.white_taps    <= WHITE_TAPS_RST;
      cfg_r.periodic_taps <= PERIODIC_TAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLOCK_IN:      cfg_r.clock_in      <= cfg_data[21:0];
        CFG_SAMPLE_RATE:   cfg_r.sample_rate   <= cfg_data[17:0];
        CFG_LFSR_PRESET:   cfg_r.lfsr_preset   <= cfg_data;
        CFG_WHITE_TAPS:    cfg_r.white_taps    <= cfg_data;
        CFG_PERIODIC_TAPS: cfg_r.periodic_taps <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psg_front #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_chip   (in_chip),
    .in_data   (in_data),
    .in_mix_in (in_mix_in),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .fq_count  (fq_count)
  );

  psg_back #(
    .NUM_CHIPS         (NUM_CHIPS),
    .VOLUME_FULL_SCALE (VOLUME_FULL_SCALE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_chip_out (out_chip_out),
    .bk_st        (bk_st)
  );

  // An empty queue always takes a transaction.
  `PSG_ASSERT_IMPL(a_empty_no_stall, fq_count == 2'd0, !in_stall, "stall with empty queue")
  // A new result comes only from the summing step.
  `PSG_ASSERT_IMPL(a_out_from_sum, $rose(out_valid), $past(bk_st.summing), "result outside sum")
  // The divider runs only for an operation in progress.
  `PSG_ASSERT_IMPL(a_div_not_idle, bk_st.div_busy, !bk_st.idle, "divider busy while idle")
  // A pop from a full queue frees a slot for the next cycle.
  `PSG_ASSERT_NEXT(a_pop_leaves_room, q_pop && fq_count == 2'd2, !in_stall || in_valid, "queue stuck after pop")

endmodule

// ===== test/tb_psg_tone_noise_synth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for psg_tone_noise_synth
// Drives command bytes and sample ticks into both generators and checks
// every sample against a predictor of the tone, noise and mixing behavior.
// Configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_psg_tone_noise_synth;
  import psg_pkg::*;

  localparam int NCHIP = 2;
  localparam int FULL_SCALE = 7680;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  logic in_chip;
  logic [7:0] in_data;
  logic signed [15:0] in_mix_in;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_sample;
  logic out_chip_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // Model of the generators.
  logic [21:0] m_clock;
  logic [17:0] m_rate;
  logic [31:0] m_preset, m_white_taps, m_periodic_taps;
  logic [12:0] atten[16];
  logic [1:0] m_cur[NCHIP];
  logic [9:0] m_div[NCHIP][4];
  logic [12:0] m_vol[NCHIP][4];
  logic m_muted[NCHIP][4];
  logic m_pol[NCHIP][4];
  logic [31:0] m_phase[NCHIP][4];
  logic [31:0] m_inc[NCHIP][4];
  logic [31:0] m_lfsr[NCHIP];
  logic m_white[NCHIP];
  logic [2:0] m_nmode[NCHIP];

  // Samples still expected, oldest first.
  logic signed [15:0] exp_sample_q[$];
  logic exp_chip_q[$];

  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_off;
  int hold_count;

  psg_tone_noise_synth u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_chip(in_chip),
    .in_data(in_data), .in_mix_in(in_mix_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .out_chip_out(out_chip_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Phase increment from a frequency, saturated to 32 bits.
  function automatic logic [31:0] phase_step(input logic [63:0] freq, input bit dbl);
    logic [63:0] q;
    if (m_rate == 0) begin
      return 32'd0;
    end
    q = ((freq << 16) / 64'(m_rate)) << dbl;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic tone_update(input int c, input int ch, input logic [9:0] d);
    if (d <= 2) begin
      m_muted[c][ch] = 1'b1;
    end else begin
      m_muted[c][ch] = 1'b0;
      m_inc[c][ch] = phase_step(64'(m_clock) / (64'(d) * 64'd32), 1'b1);
    end
  endtask

  task automatic model_reset();
    logic [63:0] acc;
    acc = 64'(FULL_SCALE) << 22;
    m_clock = CLOCK_IN_RST;
    m_rate = SAMPLE_RATE_RST;
    m_preset = LFSR_PRESET_RST;
    m_white_taps = WHITE_TAPS_RST;
    m_periodic_taps = PERIODIC_TAPS_RST;
    atten[0] = 13'(FULL_SCALE);
    for (int i = 1; i < 15; i++) begin
      acc = acc * 64'd250000000 / 64'd314731353;
      atten[i] = acc[34:22];
    end
    atten[15] = '0;
    for (int c = 0; c < NCHIP; c++) begin
      m_cur[c] = '0;
      for (int j = 0; j < 4; j++) begin
        m_div[c][j] = '0;
        m_vol[c][j] = '0;
        m_muted[c][j] = 1'b0;
        m_pol[c][j] = 1'b0;
        m_phase[c][j] = '0;
        m_inc[c][j] = '0;
      end
      m_lfsr[c] = m_preset;
      m_nmode[c] = '0;
      m_white[c] = 1'b0;
      m_pol[c][3] = m_preset[0];
      m_inc[c][3] = phase_step(64'(m_clock) / 64'd512, 1'b0);
    end
  endtask

  // Apply one command byte to a generator.
  task automatic apply_byte(input int c, input logic [7:0] v);
    int ch;
    if (v[7]) begin
      ch = v[6:5];
      m_cur[c] = v[6:5];
      if (v[4]) begin
        m_vol[c][ch] = atten[v[3:0]];
      end else if (ch < 3) begin
        m_div[c][ch] = {m_div[c][ch][9:4], v[3:0]};
      end else begin
        m_nmode[c] = v[2:0];
        m_white[c] = v[2];
        if (v[1:0] == 2'd3) begin
          tone_update(c, 3, m_div[c][2]);
        end else begin
          m_muted[c][3] = 1'b0;
          m_inc[c][3] = phase_step((64'(m_clock) / 64'd512) >> v[1:0], 1'b0);
        end
        m_lfsr[c] = m_preset;
        m_pol[c][3] = m_preset[0];
      end
    end else begin
      ch = m_cur[c];
      m_div[c][ch] = {v[5:0], m_div[c][ch][3:0]};
      if (ch != 3) begin
        tone_update(c, ch, m_div[c][ch]);
      end else if (m_nmode[c][1:0] == 2'd3) begin
        tone_update(c, 3, m_div[c][2]);
      end
    end
  endtask

  // Advance one generator by a sample and return the mixed value.
  function automatic logic signed [15:0] tick_mix(input int c, input logic signed [15:0] mix);
    int s;
    s = int'(mix);
    for (int j = 0; j < 4; j++) begin
      if (m_vol[c][j] != 0 && !m_muted[c][j]) begin
        m_phase[c][j] = m_phase[c][j] + m_inc[c][j];
        if (m_phase[c][j][16]) begin
          m_phase[c][j] = m_phase[c][j] & 32'hFFFF;
          if (j != 3) begin
            m_pol[c][j] = !m_pol[c][j];
          end else begin
            if (m_lfsr[c][0]) begin
              m_lfsr[c] ^= m_white[c] ? m_white_taps : m_periodic_taps;
            end
            m_lfsr[c] = m_lfsr[c] >> 1;
            m_pol[c][3] = m_lfsr[c][0];
          end
        end
        s += m_pol[c][j] ? -int'(m_vol[c][j]) : int'(m_vol[c][j]);
      end
    end
    if (s < -32768) s = -32768;
    if (s > 32767) s = 32767;
    return 16'(s);
  endfunction

  // Send one transaction and record what it should produce.
  // Valid stays high after acceptance until the next item or an idle cycle.
  task automatic send_item(input logic cmd, input logic chip, input logic [7:0] data,
                           input logic signed [15:0] mix);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_chip <= chip;
    in_data <= data;
    in_mix_in <= mix;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (cmd == CMD_WRITE) begin
      apply_byte(chip, data);
    end else begin
      exp_sample_q.push_back(tick_mix(chip, mix));
      exp_chip_q.push_back(chip);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_sample_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLOCK_IN: m_clock = val[21:0];
      CFG_SAMPLE_RATE: m_rate = val[17:0];
      CFG_LFSR_PRESET: m_preset = val;
      CFG_WHITE_TAPS: m_white_taps = val;
      CFG_PERIODIC_TAPS: m_periodic_taps = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic rand_tick();
    send_item(CMD_TICK, 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Channel setup: volume, low divider or noise mode, maybe high divider bits.
  task automatic rand_setup(input logic chip);
    logic [1:0] ch;
    ch = 2'($urandom);
    send_item(CMD_WRITE, chip, {1'b1, ch, 1'b1, 4'($urandom_range(14, 0))}, 16'($urandom));
    send_item(CMD_WRITE, chip, {1'b1, ch, 1'b0, 4'($urandom)}, 16'($urandom));
    if (ch != 2'd3 || $urandom_range(1, 0)) begin
      send_item(CMD_WRITE, chip, {1'b0, 1'($urandom), 6'($urandom)}, 16'($urandom));
    end
  endtask

  // Mostly ticks with occasional setups and stray bytes.
  task automatic rand_burst(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9, 0))
        0: rand_setup(1'($urandom));
        1: send_item(CMD_WRITE, 1'($urandom), 8'($urandom), 16'($urandom));
        default: rand_tick();
      endcase
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // Ticks on an idle generator return mix_in at the extremes.
    send_item(CMD_TICK, 1'b0, 8'hFF, 16'sh7FFF);
    send_item(CMD_TICK, 1'b1, 8'h00, -16'sh8000);
    // Full volume on every channel of chip 0, then ticks at both mix extremes.
    send_item(CMD_WRITE, 1'b0, 8'h90, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hB0, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hD0, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hF0, 16'sh0);
    send_item(CMD_TICK, 1'b0, 8'h00, 16'sh7FFF);
    send_item(CMD_TICK, 1'b0, 8'h00, -16'sh8000);
    // Low dividers mute; bit 6 of a data byte is ignored.
    send_item(CMD_WRITE, 1'b0, 8'h82, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'h40, 16'sh0);
    send_item(CMD_TICK, 1'b0, 8'h00, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hA1, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'h3F, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hC3, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'h7F, 16'sh0);
    // White noise and noise that follows channel 2.
    send_item(CMD_WRITE, 1'b0, 8'hE4, 16'sh0);
    send_item(CMD_TICK, 1'b0, 8'h00, 16'sh1234);
    send_item(CMD_WRITE, 1'b0, 8'hE7, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'h05, 16'sh0);
    send_item(CMD_WRITE, 1'b0, 8'hDF, 16'sh0);
    send_item(CMD_TICK, 1'b0, 8'h00, -16'sh1);
    send_item(CMD_TICK, 1'b1, 8'h00, 16'sh0);
    drain();
  endtask

  task automatic test_config_extremes();
    // Zero sample rate gives zero increments.
    write_reg(CFG_SAMPLE_RATE, 32'd0);
    rand_setup(1'b1);
    rand_burst(20);
    drain();
    // Clock of 1024, rate of 192000, all-ones white taps and preset, zero periodic taps.
    write_reg(CFG_CLOCK_IN, 32'd1024);
    write_reg(CFG_SAMPLE_RATE, 32'd192000);
    write_reg(CFG_LFSR_PRESET, 32'hFFFF_FFFF);
    write_reg(CFG_WHITE_TAPS, 32'hFFFF_FFFF);
    write_reg(CFG_PERIODIC_TAPS, 32'h0);
    rand_burst(40);
    drain();
    // Largest clock and a sample rate of 1 push tone increments into saturation.
    write_reg(CFG_CLOCK_IN, 32'h3F_FFFF);
    write_reg(CFG_SAMPLE_RATE, 32'd1);
    write_reg(CFG_LFSR_PRESET, 32'h0000_0001);
    write_reg(CFG_WHITE_TAPS, 32'h8000_0000);
    write_reg(CFG_PERIODIC_TAPS, 32'hFFFF_FFFF);
    rand_burst(40);
    drain();
    write_reg(CFG_CLOCK_IN, 32'd4000000);
    write_reg(CFG_SAMPLE_RATE, 32'd8000);
    write_reg(CFG_LFSR_PRESET, $urandom);
    write_reg(CFG_WHITE_TAPS, $urandom);
    write_reg(CFG_PERIODIC_TAPS, $urandom);
  endtask

  task automatic test_random_idling();
    idle_pct = 86;
    rand_burst(120);
    idle_pct = 0;
    stall_pct = 86;
    rand_burst(120);
    idle_pct = 7;
    stall_pct = 7;
    rand_burst(150);
    idle_pct = 0;
    stall_pct = 0;
    rand_burst(100);
    drain();
  endtask

  // The receiver holds off while items keep coming, then the sender waits.
  task automatic test_back_pressure();
    hold_req = 1'b1;
    rand_burst(40);
    hold_req = 1'b0;
    drain();
    rand_burst(30);
    drain();
  endtask

  // Receiver stall driver with a long hold-off stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Hold-off counter: the stretch ends once hold_count reaches its limit.
  always @(posedge clk) begin
    if (!hold_req) begin
      hold_count <= 0;
      hold_off <= 1'b0;
    end else if (hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      hold_off <= 1'b1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_sample_q.size() == 0) begin
        $error("unexpected sample %0d chip %0d", out_sample, out_chip_out);
        errors++;
      end else begin
        if (out_sample !== exp_sample_q[0]) begin
          $error("sample: expected %0d, actual %0d", exp_sample_q[0], out_sample);
          errors++;
        end
        if (out_chip_out !== exp_chip_q[0]) begin
          $error("chip_out: expected %0d, actual %0d", exp_chip_q[0], out_chip_out);
          errors++;
        end
        void'(exp_sample_q.pop_front());
        void'(exp_chip_q.pop_front());
      end
    end
  end

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_chip = 1'b0;
    in_data = '0;
    in_mix_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_idling();
    test_back_pressure();
    if (errors == 0 && exp_sample_q.size() == 0) begin
      $display("** psg_tone_noise_synth: PASSED **");
    end else begin
      $display("** psg_tone_noise_synth: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** psg_tone_noise_synth: FAILED **");
    $finish;
  end

endmodule
